FILE: rtl/itra_pkg.sv
// Shared constants, types and helper functions for the radix-to-ASCII converter.
package itra_pkg;

	localparam int DIGIT_SLOTS = 22;
	localparam int DIG_W       = 4;
	localparam int DIGITS_W    = DIGIT_SLOTS * DIG_W;
	localparam int VALUE_W     = 64;
	localparam int KIND_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int MAXD_W      = 5;
	localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
	localparam int BIT_CNT_W   = $clog2(VALUE_W);

	localparam logic [MAXD_W-1:0] MAXD_RESET = 5'd22;

	localparam logic [KIND_W-1:0] KIND_OCT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEC = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HEX = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_A    = 8'd97;

	typedef enum logic {
		CV_IDLE,
		CV_RUN
	} conv_state_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_TRIM,
		EM_SKIP,
		EM_EMIT
	} emit_state_t;

	// Hand-off from the converter to the emitter.
	typedef struct packed {
		logic                load;
		logic [DIGITS_W-1:0] digits;
	} itra_hand_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = CHAR_ZERO + CHAR_W'(d);
		end else begin
			r = CHAR_A + CHAR_W'(d) - 8'd10;
		end
		return r;
	endfunction

	// Spread 3-bit octal digits into the 4-bit digit slots.
	function automatic logic [DIGITS_W-1:0] pack_octal(input logic [VALUE_W-1:0] m);
		logic [DIGITS_W-1:0] r;
		r = '0;
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			for (int k = 0; k < 3; k++) begin
				if (3 * i + k < VALUE_W) begin
					r[DIG_W * i + k] = m[3 * i + k];
				end
			end
		end
		return r;
	endfunction

	function automatic logic [DIGITS_W-1:0] pack_hex(input logic [VALUE_W-1:0] m);
		logic [DIGITS_W-1:0] r;
		r = '0;
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			for (int k = 0; k < DIG_W; k++) begin
				if (DIG_W * i + k < VALUE_W) begin
					r[DIG_W * i + k] = m[DIG_W * i + k];
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/itra_conv.sv
// Magnitude and digit generation: direct split for octal and hex, shift-add-3 for decimal.
module itra_conv import itra_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VALUE_W-1:0]  value,
	output itra_hand_t          hand,
	output logic                busy
);

	conv_state_t            state_q, state_nxt;
	logic                   done_q;
	logic [BIT_CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0]     bin_q;
	logic [DIGITS_W-1:0]    digits_q;
	logic [VALUE_W-1:0]     mag;
	logic [DIGITS_W-1:0]    adj;
	logic                   run_end;

	assign mag     = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
	assign run_end = (cnt_q == BIT_CNT_W'(VALUE_W - 1));

	// Each BCD digit of 5 or more gets 3 added before the shift.
	always_comb begin
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (digits_q[DIG_W*i +: DIG_W] >= 4'd5) begin
				adj[DIG_W*i +: DIG_W] = digits_q[DIG_W*i +: DIG_W] + 4'd3;
			end else begin
				adj[DIG_W*i +: DIG_W] = digits_q[DIG_W*i +: DIG_W];
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CV_IDLE: begin
				if (start && kind == KIND_DEC) begin
					state_nxt = CV_RUN;
				end
			end
			CV_RUN: begin
				if (run_end) begin
					state_nxt = CV_IDLE;
				end
			end
			default: state_nxt = CV_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q != CV_IDLE) || done_q;
		hand.load   = done_q;
		hand.digits = digits_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == CV_IDLE && start && kind != KIND_DEC) ||
			           (state_q == CV_RUN && run_end);
			if (state_q == CV_RUN) begin
				cnt_q <= cnt_q + BIT_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CV_IDLE && start) begin
			case (kind)
				KIND_DEC: begin
					bin_q    <= mag;
					digits_q <= '0;
				end
				KIND_OCT: digits_q <= pack_octal(mag);
				default:  digits_q <= pack_hex(mag);
			endcase
		end else if (state_q == CV_RUN) begin
			digits_q <= {adj[DIGITS_W-2:0], bin_q[VALUE_W-1]};
			bin_q    <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

endmodule

FILE: rtl/itra_emit.sv
// Digit shifter: drops excess high digits, skips leading zeros, sends one character a cycle unless stalled.
module itra_emit import itra_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  itra_hand_t         hand,
	input  logic [CNT_W-1:0]   lim,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [CHAR_W-1:0]  out_char,
	output logic               last,
	output logic               busy
);

	emit_state_t          state_q, state_nxt;
	logic [DIGITS_W-1:0]  dig_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     drop_q;
	logic                 cut_q;
	logic [CNT_W-1:0]     drop_init;
	logic [DIG_W-1:0]     top;
	logic                 skip_zero;
	logic                 xfer;

	// Once a nonzero high digit has been dropped, the kept digits are sent as they are,
	// leading zeros included.
	assign drop_init = CNT_W'(DIGIT_SLOTS) - lim;
	assign top       = dig_q[DIGITS_W-1 -: DIG_W];
	assign skip_zero = !cut_q && (top == '0) && (rem_q > CNT_W'(1));
	assign xfer      = (state_q == EM_EMIT) && !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			EM_IDLE: begin
				if (hand.load) begin
					state_nxt = (drop_init == '0) ? EM_SKIP : EM_TRIM;
				end
			end
			EM_TRIM: begin
				if (drop_q == CNT_W'(1)) begin
					state_nxt = EM_SKIP;
				end
			end
			EM_SKIP: begin
				if (!skip_zero) begin
					state_nxt = EM_EMIT;
				end
			end
			EM_EMIT: begin
				if (!out_stall && rem_q == CNT_W'(1)) begin
					state_nxt = EM_IDLE;
				end
			end
			default: state_nxt = EM_IDLE;
		endcase
	end

	always_comb begin
		out_valid = (state_q == EM_EMIT);
		busy      = (state_q != EM_IDLE);
		out_char  = digit_char(top);
		last      = (rem_q == CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			rem_q   <= '0;
			drop_q  <= '0;
			cut_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == EM_IDLE && hand.load) begin
				rem_q  <= lim;
				drop_q <= drop_init;
				cut_q  <= 1'b0;
			end else begin
				if (state_q == EM_TRIM) begin
					drop_q <= drop_q - CNT_W'(1);
					if (top != '0) begin
						cut_q <= 1'b1;
					end
				end
				if ((state_q == EM_SKIP && skip_zero) || xfer) begin
					rem_q <= rem_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EM_IDLE && hand.load) begin
			dig_q <= hand.digits;
		end else if (state_q == EM_TRIM || (state_q == EM_SKIP && skip_zero) || xfer) begin
			dig_q <= {dig_q[DIGITS_W-DIG_W-1:0], {DIG_W{1'b0}}};
		end
	end

endmodule

FILE: rtl/integer_to_radix_ascii_core.sv
// Top level of the signed integer to octal, decimal or hex ASCII converter.
// The input channel (in_valid, in_stall, kind, value) takes one signed 64-bit
// integer and a radix selector per transfer. Octal, decimal and lower-case hex
// are supported, and the unused selector code behaves as hex. The magnitude is
// converted; no sign character is produced.
// The output channel (out_valid, out_stall, out_char, last) delivers one ASCII
// digit per transfer, most significant first, with last set on the final one.
// Zero gives the single character '0'. When the magnitude has more digits than
// max_digits, only the least significant max_digits digits are sent.
// max_digits is written through cfg_wr_en and cfg_wr_data; the user writes it
// only while the block is idle, which the block itself does not enforce.
// Zero acts as one and values above the slot count act as the slot count.
// Octal and hex digits are split directly into a register; decimal runs a
// shift-add-3 loop, one magnitude bit per cycle. The shifter then drops excess
// high digits, skips leading zeros (none once a nonzero digit was dropped) and
// sends one character per cycle while out_stall is low. The next item is taken
// in the cycle after the last character transfers. One item is
// worked on at a time, so in_stall stays high from the accepting edge until the
// final transfer. A stalled receiver simply holds the current character and its
// last flag. Reset clears the control state and sets max_digits back to 22.
module integer_to_radix_ascii_core import itra_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [KIND_W-1:0]          kind,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [CHAR_W-1:0]          out_char,
	output logic                       last,
	input  logic                       cfg_wr_en,
	input  logic [MAXD_W-1:0]          cfg_wr_data
);

	logic [MAXD_W-1:0] max_digits_q;
	logic [CNT_W-1:0]  lim;
	logic              conv_busy;
	logic              emit_busy;
	logic              start;
	itra_hand_t        hand;

	// Clamp the digit limit to the range one to the number of digit slots.
	always_comb begin
		if (max_digits_q == '0) begin
			lim = CNT_W'(1);
		end else if (CNT_W'(max_digits_q) > CNT_W'(DIGIT_SLOTS)) begin
			lim = CNT_W'(DIGIT_SLOTS);
		end else begin
			lim = CNT_W'(max_digits_q);
		end
	end

	// The input waits whenever either stage still holds an item.
	assign in_stall = conv_busy || emit_busy;
	assign start    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_digits_q <= MAXD_RESET;
		end else if (cfg_wr_en) begin
			max_digits_q <= cfg_wr_data;
		end
	end

	itra_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.value  (value),
		.hand   (hand),
		.busy   (conv_busy)
	);

	itra_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.hand      (hand),
		.lim       (lim),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_char  (out_char),
		.last      (last),
		.busy      (emit_busy)
	);

endmodule

FILE: rtl/itra_checker.sv
// Port-level checks for the converter top level, attached with a bind.
module itra_checker import itra_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [CHAR_W-1:0]          out_char,
	input logic                       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
		else $error("stalled output character changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("input not held off after a transfer");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while characters are pending");

	a_digit_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= 8'd48 && out_char <= 8'd57) ||
		              (out_char >= 8'd97 && out_char <= 8'd102))
		else $error("output character is not a digit");

endmodule

bind integer_to_radix_ascii_core itra_checker u_itra_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the radix-to-ASCII digit converter.
module testbench;
	import itra_pkg::*;

	// The selector code that the block does not name; it must behave as hex.
	localparam logic [KIND_W-1:0] KIND_HEX_ALT = 2'd3;

	// Cycles to wait after the last expected digit before the block counts as idle.
	// The block takes its next item in the cycle after the final transfer, so this
	// wait is plenty.
	localparam int SETTLE_CYCLES = 8;
	// Length of the receiver hold-off that backs the block up into its input.
	localparam int HOLD_CYCLES = 400;
	// Cycles without any transfer before the run is declared hung. The slowest
	// legitimate gap is the hold-off plus one decimal conversion, so this leaves a
	// wide margin.
	localparam int STALL_LIMIT = 3000;

	// Keeps the running limit on digits and the characters still owed by the
	// block. Each accepted conversion appends its characters in the order the
	// block must send them, so the oldest owed character is always at the front.
	class digit_scoreboard;
		typedef struct {
			logic [CHAR_W-1:0] ch;
			logic              is_last;
		} owed_digit_t;

		owed_digit_t        owed_digits[$];
		logic [MAXD_W-1:0]  max_digits;
		int                 mismatches;

		function new();
			max_digits = MAXD_RESET;
			mismatches = 0;
		endfunction

		function void set_max_digits(input logic [MAXD_W-1:0] v);
			max_digits = v;
		endfunction

		function int pending();
			return owed_digits.size();
		endfunction

		// Converts the magnitude of one accepted value and queues its characters.
		function void note_conversion(input logic [KIND_W-1:0] k,
				input logic [VALUE_W-1:0] v);
			logic [VALUE_W-1:0] mag;
			logic [VALUE_W-1:0] radix;
			logic [VALUE_W-1:0] d;
			logic [CHAR_W-1:0]  digits [DIGIT_SLOTS];
			int                 lim;
			int                 count;
			owed_digit_t        e;
			lim = int'(max_digits);
			if (lim == 0) begin
				lim = 1;
			end
			if (lim > DIGIT_SLOTS) begin
				lim = DIGIT_SLOTS;
			end
			case (k)
				KIND_OCT: radix = 64'd8;
				KIND_DEC: radix = 64'd10;
				default:  radix = 64'd16;
			endcase
			// The most negative value negates to itself, which read unsigned is 2^63.
			mag = v[VALUE_W-1] ? (~v + 64'd1) : v;
			count = 0;
			while (mag != 0 && count < lim) begin
				d = mag % radix;
				digits[count] = (d < 64'd10) ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d) - 8'd10;
				count++;
				mag = mag / radix;
			end
			if (count == 0) begin
				digits[0] = CHAR_ZERO;
				count = 1;
			end
			for (int i = count - 1; i >= 0; i--) begin
				e.ch = digits[i];
				e.is_last = (i == 0);
				owed_digits.push_back(e);
			end
		endfunction

		function void check_digit(input logic [CHAR_W-1:0] ch, input logic lst);
			owed_digit_t e;
			if (owed_digits.size() == 0) begin
				$error("out_char %0d arrived with no conversion pending", ch);
				mismatches++;
				return;
			end
			e = owed_digits.pop_front();
			if (ch !== e.ch) begin
				$error("out_char mismatch: expected %0d, actual %0d", e.ch, ch);
				mismatches++;
			end
			if (lst !== e.is_last) begin
				$error("last mismatch: expected %0d, actual %0d", e.is_last, lst);
				mismatches++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_stall;
	logic [CHAR_W-1:0]         out_char;
	logic                      last;
	logic                      cfg_wr_en;
	logic [MAXD_W-1:0]         cfg_wr_data;

	digit_scoreboard sb;

	// Idle rates in percent for the sending and receiving sides; the main
	// sequence changes them from phase to phase.
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	// Raised by the main sequence to ask the receiver for one long hold-off.
	logic hold_request = 1'b0;
	int  quiet_cycles = 0;

	integer_to_radix_ascii_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last        (last),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Both channels are sampled at the rising edge, where every input driven at
	// the previous falling edge has long settled and the block's own updates
	// have not yet landed. An input transfer queues its characters; an output
	// transfer is checked against the oldest character still owed.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_conversion(kind, value);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			sb.check_digit(out_char, last);
		end
	end

	// Watchdog: any transfer on either channel restarts the count of quiet cycles.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver: stalls at random at the current rate. When a hold-off is asked
	// for it keeps out_stall high for a fixed number of cycles, counted here,
	// while the sender keeps offering items so that the block backs up and
	// raises in_stall. Outside a hold-off, exactly one assignment to out_stall
	// happens per falling edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Random operand with a spread of magnitudes: full width, a random number of
	// significant bits, or a small number, each of them negated half the time.
	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(3))
			0: v = v;
			1: v = v >> $urandom_range(VALUE_W - 1);
			2: v = VALUE_W'($urandom_range(1000));
			default: v = v >> $urandom_range(VALUE_W - 8, 20);
		endcase
		if ($urandom_range(1) == 1) begin
			v = ~v + 64'd1;
		end
		return v;
	endfunction

	// Offers one item and returns at the falling edge after it was accepted.
	// Called at a falling edge. During an idle gap the payload is scrambled to
	// show that the block ignores it while in_valid is low.
	task automatic send_conversion(input logic [KIND_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			kind <= KIND_W'($urandom_range(3));
			value <= random_value();
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stops offering items, waits until every owed character has been checked,
	// then lets the block finish its hand-back to idle.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// The register is written only with the block idle; the predictor takes the
	// new limit at the same edge as the block does.
	task automatic write_max_digits(input logic [MAXD_W-1:0] v);
		drain_and_settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.set_max_digits(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random_phase(input int count, input int send_pct,
			input int recv_pct, input logic with_hold);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (with_hold) begin
			hold_request = 1'b1;
		end
		repeat (count) begin
			send_conversion(KIND_W'($urandom_range(3)), random_value());
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_OCT;
		value = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset limit of 22 digits, where nothing is cut.
		// Zero in every radix, including the unnamed selector that acts as hex.
		send_idle_pct = 14;
		recv_idle_pct = 69;
		send_conversion(KIND_OCT, 64'h0);
		send_conversion(KIND_DEC, 64'h0);
		send_conversion(KIND_HEX, 64'h0);
		send_conversion(KIND_HEX_ALT, 64'h0);
		// The most negative value: its magnitude 2^63 is the longest octal string.
		send_conversion(KIND_OCT, 64'h8000_0000_0000_0000);
		send_conversion(KIND_DEC, 64'h8000_0000_0000_0000);
		send_conversion(KIND_HEX, 64'h8000_0000_0000_0000);
		send_conversion(KIND_HEX_ALT, 64'h8000_0000_0000_0000);
		// Largest positive value and minus one.
		send_conversion(KIND_OCT, 64'h7fff_ffff_ffff_ffff);
		send_conversion(KIND_DEC, 64'h7fff_ffff_ffff_ffff);
		send_conversion(KIND_HEX, 64'h7fff_ffff_ffff_ffff);
		send_conversion(KIND_OCT, 64'hffff_ffff_ffff_ffff);
		send_conversion(KIND_DEC, 64'hffff_ffff_ffff_ffff);
		send_conversion(KIND_HEX, 64'hffff_ffff_ffff_ffff);
		// Digit boundaries in decimal and hex, and every digit character in each radix but the octal zero.
		send_conversion(KIND_DEC, 64'd9);
		send_conversion(KIND_DEC, 64'd10);
		send_conversion(KIND_HEX, 64'd15);
		send_conversion(KIND_HEX, 64'd16);
		send_conversion(KIND_HEX, 64'h0123_4567_89ab_cdef);
		send_conversion(KIND_HEX_ALT, 64'hfedc_ba98_7654_3210);
		send_conversion(KIND_DEC, 64'd1234567890);
		send_conversion(KIND_OCT, 64'h0005_3977);
		send_conversion(KIND_DEC, 64'hffff_ffff_ffff_fff6);

		// Random phases. The limit goes through its full value, zero (acting as
		// one), one, the top code and a code just above the slot count (both
		// acting as the slot count), and a random truncating value.
		write_max_digits(MAXD_W'(22));
		run_random_phase(100, 14, 69, 1'b0);
		write_max_digits(MAXD_W'(0));
		run_random_phase(30, 69, 14, 1'b0);
		write_max_digits(MAXD_W'(1));
		run_random_phase(30, 69, 14, 1'b0);
		write_max_digits(MAXD_W'(31));
		run_random_phase(30, 69, 14, 1'b0);
		write_max_digits(MAXD_W'(23));
		run_random_phase(30, 69, 14, 1'b0);
		// Last phase runs at full rate on both sides, apart from one long
		// receiver hold-off at its start.
		write_max_digits(MAXD_W'($urandom_range(21, 2)));
		run_random_phase(90, 0, 0, 1'b1);

		drain_and_settle();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
